// File: rtl/ttlin_pkg.sv
// ----------------------------------------------------------------------------
// ttlin_pkg
// Shared types, constants and the calibration ROM for the NTC thermistor
// table linearizer.
// ----------------------------------------------------------------------------
package ttlin_pkg;

  localparam int ROM_LEN           = 101;
  localparam int TABLE_ENTRIES_DEF = 101;
  localparam int SAMPLE_W          = 12;
  localparam int TEMP_W            = 11;
  localparam int IDX_W             = $clog2(ROM_LEN + 1);
  localparam int UNIT_W            = 16;
  localparam int QUO_W             = 4;
  localparam int BIT_W             = $clog2(QUO_W);
  localparam int STEP_TENTHS       = 10;
  localparam int BASE_TENTHS       = 300;
  localparam int S_TDATA_W         = 16;
  localparam int M_TDATA_W         = 16;

  // calibration codes, one per degree from -30 C, strictly descending
  localparam logic [SAMPLE_W-1:0] NTC_ROM [ROM_LEN] = '{
    12'd3924, 12'd3915, 12'd3906, 12'd3896, 12'd3886, 12'd3876, 12'd3865, 12'd3853,
    12'd3842, 12'd3829, 12'd3817, 12'd3804, 12'd3790, 12'd3776, 12'd3761, 12'd3746,
    12'd3730, 12'd3714, 12'd3698, 12'd3682, 12'd3663, 12'd3644, 12'd3626, 12'd3606,
    12'd3586, 12'd3566, 12'd3545, 12'd3523, 12'd3501, 12'd3478, 12'd3455, 12'd3431,
    12'd3407, 12'd3382, 12'd3356, 12'd3330, 12'd3304, 12'd3277, 12'd3249, 12'd3221,
    12'd3192, 12'd3163, 12'd3134, 12'd3104, 12'd3073, 12'd3042, 12'd3011, 12'd2979,
    12'd2947, 12'd2914, 12'd2881, 12'd2848, 12'd2815, 12'd2781, 12'd2747, 12'd2713,
    12'd2678, 12'd2643, 12'd2608, 12'd2573, 12'd2538, 12'd2503, 12'd2467, 12'd2432,
    12'd2397, 12'd2361, 12'd2325, 12'd2290, 12'd2255, 12'd2219, 12'd2184, 12'd2149,
    12'd2107, 12'd2079, 12'd2044, 12'd2010, 12'd1975, 12'd1941, 12'd1907, 12'd1874,
    12'd1840, 12'd1807, 12'd1774, 12'd1742, 12'd1710, 12'd1678, 12'd1647, 12'd1615,
    12'd1585, 12'd1554, 12'd1524, 12'd1495, 12'd1466, 12'd1437, 12'd1409, 12'd1381,
    12'd1353, 12'd1326, 12'd1299, 12'd1273, 12'd1247
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIFF_X,
    ST_DIFF_DEN,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEARCH,
    OP_RESOLVE,
    OP_DIFF_X,
    OP_DIFF_DEN,
    OP_DIVIDE
  } op_t;

  typedef struct packed {
    logic in_ready;
    op_t  op;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic search_done;
    logic edge_hit;
    logic div_last;
    logic out_free;
  } stat_t;

  function automatic logic [SAMPLE_W-1:0] rom_code(input logic [IDX_W-1:0] idx);
    logic [SAMPLE_W-1:0] code;
    code = '0;
    if (int'(idx) < ROM_LEN) begin
      code = NTC_ROM[idx];
    end
    return code;
  endfunction

endpackage

// File: rtl/ttlin_sub_unit.sv
// ----------------------------------------------------------------------------
// ttlin_sub_unit
// Shared subtract/compare unit: difference and borrow (a < b).
// ----------------------------------------------------------------------------
module ttlin_sub_unit (
  input  logic [ttlin_pkg::UNIT_W-1:0] a,
  input  logic [ttlin_pkg::UNIT_W-1:0] b,
  output logic [ttlin_pkg::UNIT_W-1:0] diff,
  output logic                         borrow
);
  import ttlin_pkg::*;

  logic [UNIT_W:0] wide;

  assign wide   = {1'b0, a} - {1'b0, b};
  assign diff   = wide[UNIT_W-1:0];
  assign borrow = wide[UNIT_W];

endmodule

// File: rtl/ttlin_seq.sv
// ----------------------------------------------------------------------------
// ttlin_seq
// Sequencer: binary search, span differences, restoring division, result load.
// ----------------------------------------------------------------------------
module ttlin_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  ttlin_pkg::stat_t     stat,
  output ttlin_pkg::ctl_t      ctl
);
  import ttlin_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (stat.search_done) begin
          state_next = stat.edge_hit ? ST_FINISH : ST_DIFF_X;
        end
      end
      ST_DIFF_X:   state_next = ST_DIFF_DEN;
      ST_DIFF_DEN: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (stat.div_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.in_ready = 1'b0;
    ctl.op       = OP_NONE;
    ctl.load_out = 1'b0;
    unique case (state)
      ST_IDLE:     ctl.in_ready = 1'b1;
      ST_SEARCH:   ctl.op = stat.search_done ? OP_RESOLVE : OP_SEARCH;
      ST_DIFF_X:   ctl.op = OP_DIFF_X;
      ST_DIFF_DEN: ctl.op = OP_DIFF_DEN;
      ST_DIVIDE:   ctl.op = OP_DIVIDE;
      ST_FINISH:   ctl.load_out = stat.out_free;
      default:     ctl.op = OP_NONE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.in_ready |-> (ctl.op == OP_NONE && !ctl.load_out))
    else $error("ready raised while an item is in work");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && ctl.in_ready) |=> (state == ST_SEARCH))
    else $error("accepted item did not start the search");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !stat.out_free) |=> (state == ST_FINISH))
    else $error("result dropped while output register busy");
`endif

endmodule

// File: rtl/thermistor_table_linearizer_core.sv
// ----------------------------------------------------------------------------
// thermistor_table_linearizer_core
// NTC ADC code to temperature in signed tenths of a degree, by binary search
// of a descending calibration ROM and ceiling-rounded linear interpolation.
//
//   channel  dir  payload                                   handshake
//   s_*      in   tdata[11:0] adc_sample                    tvalid/tready
//   m_*      out  tdata[10:0] temp_tenths, tuser clamped_high tvalid/tready
//
// One item at a time; samples outside the table skip the span differences
// and division. s_tready comes back the cycle after the result is loaded.
// Steps with the full table: 6 or 7 search compares, 1 resolve, 2 span
// differences, 4 restoring division steps, 1 load; the compares, differences
// and division use the one shared 16-bit subtractor. A stalled m_tready
// holds the finished result and the sequencer waits before loading the next
// one. s_tready is low during reset. Reset clears only control state.
// ----------------------------------------------------------------------------
module thermistor_table_linearizer_core #(
  parameter int TABLE_ENTRIES = ttlin_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ttlin_pkg::S_TDATA_W-1:0] s_tdata,   // [11:0] adc_sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ttlin_pkg::M_TDATA_W-1:0] m_tdata,   // [10:0] temp_tenths
  output logic                            m_tuser    // [0] clamped_high
);
  import ttlin_pkg::*;

  localparam int N_USED = (TABLE_ENTRIES > ROM_LEN) ? ROM_LEN : TABLE_ENTRIES;
  localparam logic [IDX_W-1:0] N_IDX    = IDX_W'(N_USED);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_USED - 1);
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = TEMP_W'(-BASE_TENTHS);
  localparam logic signed [TEMP_W-1:0] TEMP_MAX =
    TEMP_W'((N_USED - 1) * STEP_TENTHS - BASE_TENTHS);

  ctl_t  ctl;
  stat_t stat;

  logic [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]    lo;
  logic [IDX_W-1:0]    hi;
  logic [UNIT_W-1:0]   rem;
  logic [SAMPLE_W-1:0] den;
  logic [QUO_W-1:0]    q;
  logic [BIT_W-1:0]    bitcnt;
  logic                interp;
  logic                clamp;

  logic [TEMP_W-1:0]   temp_out;
  logic                clamp_out;

  logic [IDX_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;
  logic [IDX_W-1:0]    lo_m1;
  logic [UNIT_W-1:0]   op_a;
  logic [UNIT_W-1:0]   op_b;
  logic [UNIT_W-1:0]   diff;
  logic                borrow;
  logic [SAMPLE_W-1:0] x;
  logic [UNIT_W-1:0]   rem_init;
  logic [QUO_W-1:0]    frac;
  logic [TEMP_W-1:0]   temp_calc;
  logic                accept;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = ctl.in_ready && !rst;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];
  assign lo_m1   = lo - IDX_W'(1);

  assign stat.search_done = (lo == hi);
  assign stat.edge_hit    = (lo == '0) || (lo == N_IDX);
  assign stat.div_last    = (bitcnt == '0);
  assign stat.out_free    = !m_tvalid || m_tready;

  ttlin_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .ctl      (ctl)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctl.op)
      OP_SEARCH: begin
        op_a = UNIT_W'(rom_code(mid));
        op_b = UNIT_W'(sample);
      end
      OP_DIFF_X: begin
        op_a = UNIT_W'(sample);
        op_b = UNIT_W'(rom_code(lo));
      end
      OP_DIFF_DEN: begin
        op_a = UNIT_W'(rom_code(lo_m1));
        op_b = UNIT_W'(rom_code(lo));
      end
      OP_DIVIDE: begin
        op_a = rem;
        op_b = UNIT_W'(den) << bitcnt;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  ttlin_sub_unit u_sub (
    .a      (op_a),
    .b      (op_b),
    .diff   (diff),
    .borrow (borrow)
  );

  // ceil(10x/den) = floor((10x-1)/den) + 1, x >= 1 here
  assign x        = diff[SAMPLE_W-1:0];
  assign rem_init = UNIT_W'({x, 3'b000}) + UNIT_W'({x, 1'b0}) - UNIT_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= s_tdata[SAMPLE_W-1:0];
      lo     <= '0;
      hi     <= N_IDX;
    end
    unique case (ctl.op)
      OP_SEARCH: begin
        // first entry strictly below the sample
        if (borrow) begin
          hi <= mid;
        end else begin
          lo <= mid + IDX_W'(1);
        end
      end
      OP_RESOLVE: begin
        clamp  <= (lo == N_IDX);
        interp <= (lo != '0) && (lo != N_IDX);
        if (lo == N_IDX) lo <= LAST_IDX;
      end
      OP_DIFF_X: rem <= rem_init;
      OP_DIFF_DEN: begin
        den    <= diff[SAMPLE_W-1:0];
        q      <= '0;
        bitcnt <= BIT_W'(QUO_W - 1);
      end
      OP_DIVIDE: begin
        if (!borrow) begin
          rem       <= diff;
          q[bitcnt] <= 1'b1;
        end
        bitcnt <= bitcnt - BIT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign frac      = (interp && den != '0) ? (q + QUO_W'(1)) : '0;
  assign temp_calc = TEMP_W'(lo) * TEMP_W'(STEP_TENTHS) - TEMP_W'(BASE_TENTHS)
                     - TEMP_W'(frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      temp_out  <= temp_calc;
      clamp_out <= clamp;
    end
  end

  assign m_tdata = {{(M_TDATA_W - TEMP_W){1'b0}}, temp_out};
  assign m_tuser = clamp_out;

`ifndef NO_ASSERTIONS
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_SEARCH) |-> (lo < hi && hi <= N_IDX))
    else $error("search window out of order");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.load_out && interp) |-> (q <= QUO_W'(STEP_TENTHS - 1)))
    else $error("interpolation quotient out of range");

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> ($signed(m_tdata[TEMP_W-1:0]) == TEMP_MAX))
    else $error("clamped result not at table top");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[TEMP_W-1:0]) >= TEMP_MIN &&
                  $signed(m_tdata[TEMP_W-1:0]) <= TEMP_MAX))
    else $error("temperature outside table range");
`endif

endmodule

// File: verif/thermistor_table_linearizer_core_tb.sv
// ----------------------------------------------------------------------------
// thermistor_table_linearizer_core_tb
// Streams ADC codes into the NTC linearizer and checks every temperature
// against a scoreboard predictor: a linear scan of a private copy of the
// calibration table with ceiling-rounded interpolation. Covers the table ends,
// samples on and beside calibration codes, a full drain pause, then a long
// random stream with bursty input, all under random output backpressure.
// ----------------------------------------------------------------------------
module thermistor_table_linearizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttlin_pkg::*;

  localparam int N_ENTRIES   = 101;
  localparam int CAL_LEN     = 101;
  localparam int N_SEARCHED  = (N_ENTRIES < CAL_LEN) ? N_ENTRIES : CAL_LEN;
  localparam int N_RANDOM    = 1400;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     clamped;
  } temp_result_t;

  // calibration codes, one per degree from -30 C
  logic [SAMPLE_W-1:0] cal_codes [CAL_LEN] = '{
    12'd3924, 12'd3915, 12'd3906, 12'd3896, 12'd3886, 12'd3876, 12'd3865, 12'd3853,
    12'd3842, 12'd3829, 12'd3817, 12'd3804, 12'd3790, 12'd3776, 12'd3761, 12'd3746,
    12'd3730, 12'd3714, 12'd3698, 12'd3682, 12'd3663, 12'd3644, 12'd3626, 12'd3606,
    12'd3586, 12'd3566, 12'd3545, 12'd3523, 12'd3501, 12'd3478, 12'd3455, 12'd3431,
    12'd3407, 12'd3382, 12'd3356, 12'd3330, 12'd3304, 12'd3277, 12'd3249, 12'd3221,
    12'd3192, 12'd3163, 12'd3134, 12'd3104, 12'd3073, 12'd3042, 12'd3011, 12'd2979,
    12'd2947, 12'd2914, 12'd2881, 12'd2848, 12'd2815, 12'd2781, 12'd2747, 12'd2713,
    12'd2678, 12'd2643, 12'd2608, 12'd2573, 12'd2538, 12'd2503, 12'd2467, 12'd2432,
    12'd2397, 12'd2361, 12'd2325, 12'd2290, 12'd2255, 12'd2219, 12'd2184, 12'd2149,
    12'd2107, 12'd2079, 12'd2044, 12'd2010, 12'd1975, 12'd1941, 12'd1907, 12'd1874,
    12'd1840, 12'd1807, 12'd1774, 12'd1742, 12'd1710, 12'd1678, 12'd1647, 12'd1615,
    12'd1585, 12'd1554, 12'd1524, 12'd1495, 12'd1466, 12'd1437, 12'd1409, 12'd1381,
    12'd1353, 12'd1326, 12'd1299, 12'd1273, 12'd1247
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  temp_result_t expected_temps[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_max = 0;
  logic [31:0]  stall_pat = '1;
  logic [4:0]   stall_step = '0;
  logic         sparse_ready = 1'b0;

  thermistor_table_linearizer_core #(
    .TABLE_ENTRIES(N_ENTRIES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // [11:0] adc_sample
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),   // [10:0] temp_tenths
    .m_tuser (m_tuser)    // [0] clamped_high
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // scan for the first code strictly below the sample, interpolate upward
  function automatic temp_result_t predict_temp(input logic [SAMPLE_W-1:0] sample);
    int unsigned  hit;
    int unsigned  num;
    int unsigned  span;
    int unsigned  frac;
    int           tenths;
    temp_result_t r;
    hit = N_SEARCHED;
    for (int k = 0; k < N_SEARCHED; k++) begin
      if (sample > cal_codes[k]) begin
        hit = k;
        break;
      end
    end
    r.clamped = 1'b0;
    if (hit >= N_SEARCHED) begin
      tenths    = (N_SEARCHED - 1) * STEP_TENTHS - BASE_TENTHS;
      r.clamped = 1'b1;
    end else begin
      tenths = hit * STEP_TENTHS - BASE_TENTHS;
      if (hit > 0) begin
        num  = STEP_TENTHS * (sample - cal_codes[hit]);
        span = (cal_codes[hit-1] > cal_codes[hit]) ? cal_codes[hit-1] - cal_codes[hit] : 0;
        frac = (span != 0) ? (num + span - 1) / span : 0;
        tenths -= frac;
      end
    end
    r.temp = tenths[TEMP_W-1:0];
    return r;
  endfunction

  // one item; valid stays up across back-to-back items within a burst
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-SAMPLE_W){1'b0}}, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_temps.push_back(predict_temp(sample));
  endtask

  task automatic wait_drained();
    while (expected_temps.size() != 0) @(posedge clk);
  endtask

  task automatic test_table_edges();
    logic [SAMPLE_W-1:0] edge_codes [$];
    edge_codes = '{12'd0, 12'd4095, 12'd3925, 12'd3924, 12'd3923, 12'd3916, 12'd3915,
                   12'd3914, 12'd2150, 12'd2149, 12'd2108, 12'd2107, 12'd2106,
                   12'd2080, 12'd2079, 12'd1274, 12'd1273, 12'd1249, 12'd1248,
                   12'd1247, 12'd1246, 12'd2048, 12'd2047};
    gap_max = 0;
    foreach (edge_codes[i]) send_sample(edge_codes[i]);
  endtask

  task automatic test_random_stream(input int count);
    int                  pick;
    int                  k;
    logic [SAMPLE_W-1:0] sample;
    for (int i = 0; i < count; i++) begin
      // change sender pacing every 100 items, with some gap-free stretches
      if (i % 100 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        sample = SAMPLE_W'($urandom_range(1248, 3924));
      end else if (pick < 8) begin
        k      = $urandom_range(0, CAL_LEN - 1);
        sample = SAMPLE_W'(cal_codes[k] + $urandom_range(0, 4) - 2);
      end else if (pick == 8) begin
        sample = SAMPLE_W'($urandom);
      end else begin
        sample = SAMPLE_W'($urandom_range(0, 1) ? $urandom_range(0, 1247)
                                                : $urandom_range(3925, 4095));
      end
      send_sample(sample);
    end
  endtask

  // hold the sender off until the block has handed back everything
  task automatic test_drain_pause();
    gap_max = 3;
    for (int i = 0; i < 20; i++) send_sample(SAMPLE_W'($urandom));
    s_tvalid   <= 1'b0;
    burst_left = 0;
    wait_drained();
    for (int i = 0; i < 20; i++) send_sample(SAMPLE_W'($urandom_range(1247, 3925)));
  endtask

  // receiver: ready follows a random 32-bit pattern, reloaded whenever the step counter wraps
  always @(posedge clk) begin
    stall_step <= stall_step + 5'd1;
    if (stall_step == '0) begin
      sparse_ready <= ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 3))
        0:       stall_pat <= '1;
        1:       stall_pat <= $urandom | $urandom;
        default: stall_pat <= sparse_ready ? ($urandom & $urandom & $urandom) : $urandom;
      endcase
    end
    m_tready <= stall_pat[stall_step];
  end

  always @(posedge clk) begin
    temp_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_temps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected item: temp=%0d clamped=%0b",
                   $signed(m_tdata[TEMP_W-1:0]), m_tuser);
      end else begin
        exp_r = expected_temps.pop_front();
        if (m_tdata[TEMP_W-1:0] !== exp_r.temp || m_tuser !== exp_r.clamped) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected temp=%0d clamped=%0b, got temp=%0d clamped=%0b",
                     exp_r.temp, exp_r.clamped, $signed(m_tdata[TEMP_W-1:0]), m_tuser);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("thermistor_table_linearizer_core_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_edges();
    test_drain_pause();
    test_random_stream(N_RANDOM);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("thermistor_table_linearizer_core_tb: done, clean");
    end else begin
      $display("thermistor_table_linearizer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
